@@ src/ticket_dispenser_motor_status_assert.svh @@
// assertion macros shared by the ticket dispenser motor status design
`ifndef TICKET_DISPENSER_MOTOR_STATUS_ASSERT_SVH
`define TICKET_DISPENSER_MOTOR_STATUS_ASSERT_SVH

// same-cycle implication, disabled during reset
`define TDMS_ASSERT_IMPLY(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define TDMS_ASSERT_NEXT(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ src/tdms_pkg.sv @@
// types, constants and codes of the ticket dispenser motor status block
package tdms_pkg;

    localparam int unsigned KIND_W       = 2;
    localparam int unsigned UNIT_W       = 1;
    localparam int unsigned DATA_W       = 8;
    localparam int unsigned PERIOD_W     = 16;
    localparam int unsigned COUNT_W      = 32;
    localparam int unsigned NOW_W        = 2;
    localparam int unsigned CFG_ADDR_W   = 2;
    localparam int unsigned CFG_DATA_W   = 16;
    localparam int unsigned NUM_UNITS_DEF = 2;
    localparam int unsigned MOTOR_BIT    = 7;

    localparam logic [PERIOD_W-1:0] PERIOD_RST      = 16'd100;
    localparam logic                MOTOR_POL_RST   = 1'b1;
    localparam logic                STATUS_POL_RST  = 1'b1;
    localparam logic [DATA_W-1:0]   STATUS_SET_BYTE = 8'h80;

    typedef enum logic [KIND_W-1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_TICK  = 2'd2
    } kind_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PERIOD     = 2'd0,
        CFG_MOTOR_POL  = 2'd1,
        CFG_STATUS_POL = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] period_ms;
        logic                motor_on_high;
        logic                status_active_high;
    } cfg_t;

    typedef struct packed {
        logic tick;
        logic write_on;
        logic write_off;
    } unit_ctrl_t;

    typedef struct packed {
        logic phase;
        logic expire;
        logic phase_new;
        logic power_off;
    } unit_stat_t;

endpackage

@@ src/tdms_cfg.sv @@
// configuration registers of the ticket dispenser motor status block
module tdms_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tdms_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [tdms_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output tdms_pkg::cfg_t                  cfg
);
    import tdms_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_PERIOD:     cfg_next.period_ms          = cfg_wdata[PERIOD_W-1:0];
                CFG_MOTOR_POL:  cfg_next.motor_on_high      = cfg_wdata[0];
                CFG_STATUS_POL: cfg_next.status_active_high = cfg_wdata[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period_ms          <= PERIOD_RST;
            cfg_reg.motor_on_high      <= MOTOR_POL_RST;
            cfg_reg.status_active_high <= STATUS_POL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/tdms_unit.sv @@
// one dispenser: motor power, status phase and millisecond countdown
module tdms_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tdms_pkg::unit_ctrl_t          ctrl,
    input  logic [tdms_pkg::PERIOD_W-1:0] period_ms,
    output tdms_pkg::unit_stat_t          stat
);
    import tdms_pkg::*;

    logic                powered_reg;
    logic                powered_next;
    logic                phase_reg;
    logic                phase_next;
    logic [PERIOD_W-1:0] countdown_reg;
    logic [PERIOD_W-1:0] countdown_next;
    logic                turn_on;
    logic                turn_off;
    logic                expire;

    assign turn_on  = ctrl.write_on && !powered_reg;
    assign turn_off = ctrl.write_off && powered_reg;
    // countdown of zero or one runs out on this tick
    assign expire   = ctrl.tick && powered_reg && (countdown_reg <= PERIOD_W'(1));

    always_comb
    begin
        powered_next   = powered_reg;
        phase_next     = phase_reg;
        countdown_next = countdown_reg;
        if (turn_on)
        begin
            powered_next   = 1'b1;
            phase_next     = 1'b0;
            countdown_next = period_ms;
        end
        else if (turn_off)
        begin
            powered_next = 1'b0;
        end
        else if (ctrl.tick && powered_reg)
        begin
            if (expire)
            begin
                phase_next     = !phase_reg;
                countdown_next = period_ms;
            end
            else
            begin
                countdown_next = countdown_reg - PERIOD_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            powered_reg   <= 1'b0;
            phase_reg     <= 1'b0;
            countdown_reg <= '0;
        end
        else
        begin
            powered_reg   <= powered_next;
            phase_reg     <= phase_next;
            countdown_reg <= countdown_next;
        end
    end

    assign stat.phase     = phase_reg;
    assign stat.expire    = expire;
    assign stat.phase_new = phase_next;
    assign stat.power_off = turn_off;

endmodule

@@ src/ticket_dispenser_motor_status.sv @@
// top level of the ticket dispenser motor status block
//
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------------------
//  in      | in_valid / in_stall     | kind, unit, write_data
//  out     | out_valid / out_stall   | read_data, ticket_led, ticket_count, tickets_now
//  cfg     | cfg_we                  | cfg_addr, cfg_wdata
//
// one transaction per cycle sustained while the output is not stalled; input register, then result register
// all unit and lamp state is updated together with the result register
// out_stall holds a full result register and, when the input register is full too, raises in_stall
// reset clears the valid flags and the unit, lamp and count state and loads period 100 with both polarities active high
`include "ticket_dispenser_motor_status_assert.svh"

module ticket_dispenser_motor_status #(
    parameter int unsigned NUM_UNITS = tdms_pkg::NUM_UNITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tdms_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [tdms_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [tdms_pkg::KIND_W-1:0]     kind,
    input  logic [tdms_pkg::UNIT_W-1:0]     unit,
    input  logic [tdms_pkg::DATA_W-1:0]     write_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [tdms_pkg::DATA_W-1:0]     read_data,
    output logic                            ticket_led,
    output logic [tdms_pkg::COUNT_W-1:0]    ticket_count,
    output logic [tdms_pkg::NOW_W-1:0]      tickets_now
);
    import tdms_pkg::*;

    localparam int unsigned CNT_W = $clog2(NUM_UNITS + 1);

    cfg_t                cfg;
    unit_ctrl_t          ctrl  [NUM_UNITS];
    unit_stat_t          stat  [NUM_UNITS];

    logic                s1_valid_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [UNIT_W-1:0]   unit_reg;
    logic [DATA_W-1:0]   wdata_reg;

    logic                out_valid_reg;
    logic [DATA_W-1:0]   read_data_reg;
    logic [DATA_W-1:0]   read_data_next;
    logic [NOW_W-1:0]    now_reg;
    logic                lamp_reg;
    logic                lamp_next;
    logic [COUNT_W-1:0]  total_reg;
    logic [COUNT_W-1:0]  total_next;
    logic [CNT_W-1:0]    tick_cnt;

    logic                advance;
    logic                fire;
    logic                is_read;
    logic                is_write;
    logic                is_tick;
    logic                motor_match;
    logic                read_hit;
    logic                read_phase;

    tdms_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            kind_reg  <= kind;
            unit_reg  <= unit;
            wdata_reg <= write_data;
        end
    end

    assign is_read     = fire && (kind_reg == KIND_READ);
    assign is_write    = fire && (kind_reg == KIND_WRITE);
    assign is_tick     = fire && (kind_reg == KIND_TICK);
    assign motor_match = (wdata_reg[MOTOR_BIT] == cfg.motor_on_high);

    generate
        for (genvar g = 0; g < NUM_UNITS; g++)
        begin : g_unit
            logic hit;

            assign hit                = (int'(unit_reg) == g);
            assign ctrl[g].tick       = is_tick;
            assign ctrl[g].write_on   = is_write && hit && motor_match;
            assign ctrl[g].write_off  = is_write && hit && !motor_match;

            tdms_unit u_unit (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl[g]),
                .period_ms (cfg.period_ms),
                .stat      (stat[g])
            );
        end
    endgenerate

    // status read, lamp and ticket count
    always_comb
    begin
        read_hit   = 1'b0;
        read_phase = 1'b0;
        lamp_next  = lamp_reg;
        tick_cnt   = '0;
        for (int u = 0; u < NUM_UNITS; u++)
        begin
            if (int'(unit_reg) == u)
            begin
                read_hit   = 1'b1;
                read_phase = stat[u].phase;
            end
            if (stat[u].power_off)
            begin
                lamp_next = 1'b0;
            end
            // highest expiring unit sets the lamp
            if (stat[u].expire)
            begin
                lamp_next = stat[u].phase_new;
                if (stat[u].phase_new)
                begin
                    tick_cnt = tick_cnt + CNT_W'(1);
                end
            end
        end
        total_next = total_reg + COUNT_W'(tick_cnt);
        if (is_read && read_hit && (read_phase ^ !cfg.status_active_high))
        begin
            read_data_next = STATUS_SET_BYTE;
        end
        else
        begin
            read_data_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lamp_reg  <= 1'b0;
            total_reg <= '0;
        end
        else if (fire)
        begin
            lamp_reg  <= lamp_next;
            total_reg <= total_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            read_data_reg <= read_data_next;
            now_reg       <= NOW_W'(tick_cnt);
        end
    end

    // lamp and count registers change only when a new result is loaded
    assign out_valid    = out_valid_reg;
    assign read_data    = read_data_reg;
    assign ticket_led   = lamp_reg;
    assign ticket_count = total_reg;
    assign tickets_now  = now_reg;

    `TDMS_ASSERT_IMPLY(a_stall_cause, clk, rst_n, in_stall, s1_valid_reg && out_valid_reg && out_stall)
    `TDMS_ASSERT_NEXT(a_result_loaded, clk, rst_n, fire, out_valid_reg)
    `TDMS_ASSERT_NEXT(a_total_step, clk, rst_n, fire, total_reg == $past(total_reg) + COUNT_W'($past(tick_cnt)))
    `TDMS_ASSERT_NEXT(a_read_only_data, clk, rst_n, fire && (kind_reg != KIND_READ), read_data_reg == '0)

endmodule

@@ tb/sv/testbench.sv @@
// self-checking testbench for the ticket dispenser motor status block
module testbench;
    import tdms_pkg::*;

    localparam int unsigned UNITS       = NUM_UNITS_DEF;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PHASE_ITEMS = 230;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic               ticket_led;
        logic [COUNT_W-1:0] ticket_count;
        logic [NOW_W-1:0]   tickets_now;
    } dispenser_status_t;

    class dispenser_shadow;
        logic [PERIOD_W-1:0] period_ms;
        logic                motor_high;
        logic                status_high;
        logic                powered [UNITS];
        logic                phase [UNITS];
        logic [PERIOD_W-1:0] countdown [UNITS];
        logic                lamp;
        logic [COUNT_W-1:0]  total;
        dispenser_status_t   pending_status [$];
        int unsigned         errors;

        function void clear();
            period_ms   = PERIOD_RST;
            motor_high  = MOTOR_POL_RST;
            status_high = STATUS_POL_RST;
            for (int i = 0; i < UNITS; i++)
            begin
                powered[i]   = 1'b0;
                phase[i]     = 1'b0;
                countdown[i] = '0;
            end
            lamp   = 1'b0;
            total  = '0;
            errors = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_PERIOD:     period_ms   = value[PERIOD_W-1:0];
                CFG_MOTOR_POL:  motor_high  = value[0];
                CFG_STATUS_POL: status_high = value[0];
                default: ;
            endcase
        endfunction

        // work out the status that one accepted transaction produces
        function void apply_item(logic [KIND_W-1:0] k, logic [UNIT_W-1:0] u,
                                 logic [DATA_W-1:0] d);
            dispenser_status_t want;
            want = '0;
            case (k)
                KIND_READ:
                begin
                    if (phase[u] ^ ~status_high)
                        want.read_data = STATUS_SET_BYTE;
                end
                KIND_WRITE:
                begin
                    if (d[MOTOR_BIT] == motor_high)
                    begin
                        if (!powered[u])
                        begin
                            powered[u]   = 1'b1;
                            phase[u]     = 1'b0;
                            countdown[u] = period_ms;
                        end
                    end
                    else if (powered[u])
                    begin
                        powered[u] = 1'b0;
                        lamp       = 1'b0;
                    end
                end
                KIND_TICK:
                begin
                    for (int i = 0; i < UNITS; i++)
                    begin
                        if (powered[i])
                        begin
                            if (countdown[i] <= PERIOD_W'(1))
                            begin
                                phase[i]     = ~phase[i];
                                countdown[i] = period_ms;
                                lamp         = phase[i];
                                if (phase[i])
                                begin
                                    total            = total + COUNT_W'(1);
                                    want.tickets_now = want.tickets_now + NOW_W'(1);
                                end
                            end
                            else
                                countdown[i] = countdown[i] - PERIOD_W'(1);
                        end
                    end
                end
                default: ;
            endcase
            want.ticket_led   = lamp;
            want.ticket_count = total;
            pending_status.push_back(want);
        endfunction

        function void compare_result(dispenser_status_t got);
            dispenser_status_t want;
            if (pending_status.size() == 0)
            begin
                $error("result with nothing expected: read_data %0h count %0d",
                       got.read_data, got.ticket_count);
                errors++;
                return;
            end
            want = pending_status.pop_front();
            if (got.read_data !== want.read_data)
            begin
                $error("read_data expected %0h actual %0h", want.read_data, got.read_data);
                errors++;
            end
            if (got.ticket_led !== want.ticket_led)
            begin
                $error("ticket_led expected %0b actual %0b", want.ticket_led, got.ticket_led);
                errors++;
            end
            if (got.ticket_count !== want.ticket_count)
            begin
                $error("ticket_count expected %0d actual %0d",
                       want.ticket_count, got.ticket_count);
                errors++;
            end
            if (got.tickets_now !== want.tickets_now)
            begin
                $error("tickets_now expected %0d actual %0d",
                       want.tickets_now, got.tickets_now);
                errors++;
            end
        endfunction
    endclass

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    logic [KIND_W-1:0]     kind       = '0;
    logic [UNIT_W-1:0]     unit       = '0;
    logic [DATA_W-1:0]     write_data = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    logic [DATA_W-1:0]     read_data;
    logic                  ticket_led;
    logic [COUNT_W-1:0]    ticket_count;
    logic [NOW_W-1:0]      tickets_now;

    dispenser_shadow shadow;
    int unsigned     sender_idle_pct   = 0;
    int unsigned     receiver_idle_pct = 0;
    int unsigned     hold_requests     = 0;
    int unsigned     holds_granted     = 0;
    int unsigned     hold_left         = 0;
    int unsigned     cycle_count       = 0;

    ticket_dispenser_motor_status u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .unit         (unit),
        .write_data   (write_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .read_data    (read_data),
        .ticket_led   (ticket_led),
        .ticket_count (ticket_count),
        .tickets_now  (tickets_now)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // receiver: random stall, or a long hold-off when one is requested
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else if (hold_requests != holds_granted)
        begin
            holds_granted = holds_granted + 1;
            hold_left     = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            shadow.compare_result('{read_data, ticket_led, ticket_count, tickets_now});
    end

    task automatic send_item(logic [KIND_W-1:0] k, logic [UNIT_W-1:0] u,
                             logic [DATA_W-1:0] d);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        unit       <= u;
        write_data <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        shadow.apply_item(k, u, d);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (shadow.pending_status.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        shadow.set_reg(idx, value);
    endtask

    task automatic send_random_item();
        int unsigned       pick;
        logic [DATA_W-1:0] d;
        pick = $urandom_range(99);
        d    = DATA_W'($urandom_range(255));
        if ($urandom_range(99) < 70)
            d[MOTOR_BIT] = shadow.motor_high;
        else
            d[MOTOR_BIT] = ~shadow.motor_high;
        if (pick < 50)
            send_item(KIND_TICK, UNIT_W'($urandom_range(1)), d);
        else if (pick < 75)
            send_item(KIND_READ, UNIT_W'($urandom_range(1)), d);
        else if (pick < 97)
            send_item(KIND_WRITE, UNIT_W'($urandom_range(1)), d);
        else
            send_item(KIND_UNUSED, UNIT_W'($urandom_range(1)), d);
    endtask

    task automatic run_phase(int unsigned tx_pct, int unsigned rx_pct, bit with_hold);
        write_reg(CFG_PERIOD, CFG_DATA_W'($urandom_range(1, 6)));
        write_reg(CFG_MOTOR_POL, CFG_DATA_W'($urandom_range(65535)));
        write_reg(CFG_STATUS_POL, CFG_DATA_W'($urandom_range(65535)));
        sender_idle_pct   = tx_pct;
        receiver_idle_pct = rx_pct;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            if (with_hold && i == 20)
                hold_requests = hold_requests + 1;
            send_random_item();
        end
    endtask

    initial
    begin
        shadow = new;
        shadow.clear();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: nothing powered at first, then off, on and unused transactions
        send_item(KIND_READ, 1'b0, 8'h00);
        send_item(KIND_READ, 1'b1, 8'hFF);
        send_item(KIND_UNUSED, 1'b0, 8'hFF);
        send_item(KIND_TICK, 1'b1, 8'h00);
        send_item(KIND_WRITE, 1'b1, 8'h00);
        send_item(KIND_WRITE, 1'b0, 8'h80);
        send_item(KIND_TICK, 1'b0, 8'h55);
        send_item(KIND_WRITE, 1'b0, 8'h7F);

        // zero period, both units expiring on one tick, power-on while on
        write_reg(CFG_PERIOD, 16'd0);
        send_item(KIND_WRITE, 1'b0, 8'hFF);
        send_item(KIND_WRITE, 1'b1, 8'h80);
        send_item(KIND_WRITE, 1'b1, 8'hAA);
        send_item(KIND_TICK, 1'b0, 8'h00);
        send_item(KIND_READ, 1'b0, 8'h00);
        send_item(KIND_READ, 1'b1, 8'h00);
        send_item(KIND_TICK, 1'b0, 8'h00);
        send_item(KIND_TICK, 1'b1, 8'hFF);
        send_item(KIND_WRITE, 1'b1, 8'h00);
        send_item(KIND_READ, 1'b1, 8'h00);
        send_item(KIND_TICK, 1'b0, 8'h00);

        // inverted polarities and the longest period
        write_reg(CFG_PERIOD, 16'hFFFF);
        write_reg(CFG_MOTOR_POL, 16'h0000);
        write_reg(CFG_STATUS_POL, 16'hFFFE);
        send_item(KIND_WRITE, 1'b1, 8'h7F);
        send_item(KIND_READ, 1'b1, 8'h00);
        send_item(KIND_WRITE, 1'b0, 8'h80);
        send_item(KIND_TICK, 1'b0, 8'h00);
        send_item(KIND_READ, 1'b0, 8'h00);

        run_phase(32, 81, 1'b0);
        run_phase(81, 32, 1'b0);
        run_phase(0, 0, 1'b1);

        drain();
        repeat (10) @(posedge clk);
        if (shadow.errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
